>>> hdl/lzwe_pkg.sv
// ============================================================================
// lzwe_pkg - shared constants and types of the LZW encoder
// Default sizes, the hash multiplier and the control state encoding.
// ============================================================================
package lzwe_pkg;

  localparam int LZWE_CODE_BITS    = 12;
  localparam int LZWE_HASH_ENTRIES = 8192;
  localparam int LZWE_FIRST_FREE   = 256;
  localparam int LZWE_BYTE_W       = 8;
  localparam int LZWE_HASH_MULT    = 40503;
  localparam int LZWE_HASH_MULT_W  = 16;
  localparam int LZWE_TERM_CODE    = 0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EMIT_MISS,
    ST_EMIT_PREFIX,
    ST_EMIT_TERM
  } lzwe_state_t;

endpackage

>>> hdl/lzwe_ifs.sv
// ============================================================================
// lzwe_ifs - byte input and code output channels of the LZW encoder
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
interface lzwe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output data_byte, output end_of_input, input ready);
  modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface lzwe_out_if #(
  parameter int CODE_BITS = 12
);
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] out_code;
  logic                 last_result;

  modport source (output valid, output out_code, output last_result, input ready);
  modport sink   (input valid, input out_code, input last_result, output ready);
endinterface

>>> hdl/lzwe_dict.sv
// ============================================================================
// lzwe_dict - dictionary hash table memory
// One write port, one read port with registered read data.
// ============================================================================
module lzwe_dict
  import lzwe_pkg::*;
#(
  parameter int CODE_BITS    = LZWE_CODE_BITS,
  parameter int HASH_ENTRIES = LZWE_HASH_ENTRIES,
  localparam int IDX_W       = $clog2(HASH_ENTRIES),
  localparam int ENT_W       = 1 + CODE_BITS + LZWE_BYTE_W + CODE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ENT_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ENT_W-1:0] wr_data
);

  logic [ENT_W-1:0] dict_mem_r [HASH_ENTRIES];
  logic [ENT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dict_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= dict_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

  // the controller never reads the slot it writes in the same cycle
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("dictionary read and write hit the same slot");

endmodule

>>> hdl/lzwe_ctrl.sv
// ============================================================================
// lzwe_ctrl - LZW encoder sequencer
// Hashes (prefix, byte), probes the table linearly, inserts new strings,
// emits codes and sweeps the table clear after reset and after each stream.
// ============================================================================
module lzwe_ctrl
  import lzwe_pkg::*;
#(
  parameter int CODE_BITS    = LZWE_CODE_BITS,
  parameter int HASH_ENTRIES = LZWE_HASH_ENTRIES,
  localparam int IDX_W       = $clog2(HASH_ENTRIES),
  localparam int KEY_W       = CODE_BITS + LZWE_BYTE_W,
  localparam int ENT_W       = 1 + KEY_W + CODE_BITS,
  localparam int NF_W        = CODE_BITS + 1,
  localparam int PROD_W      = KEY_W + LZWE_HASH_MULT_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // byte input
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [LZWE_BYTE_W-1:0] in_data_byte,
  input  logic                   in_end_of_input,
  // code output
  output logic                   emit_valid,
  input  logic                   emit_ready,
  output logic [CODE_BITS-1:0]   emit_code,
  output logic                   emit_last,
  // dictionary memory
  output logic                   rd_en,
  output logic [IDX_W-1:0]       rd_addr,
  input  logic [ENT_W-1:0]       rd_data,
  output logic                   wr_en,
  output logic [IDX_W-1:0]       wr_addr,
  output logic [ENT_W-1:0]       wr_data
);

  lzwe_state_t            state_r, state_nxt;
  logic [CODE_BITS-1:0]   prefix_r, prefix_nxt;
  logic                   have_prefix_r, have_prefix_nxt;
  logic [NF_W-1:0]        next_free_r, next_free_nxt;
  logic [LZWE_BYTE_W-1:0] byte_r, byte_nxt;
  logic                   last_r, last_nxt;
  logic [IDX_W-1:0]       slot_r, slot_nxt;
  logic [IDX_W-1:0]       probe_cnt_r, probe_cnt_nxt;
  logic [IDX_W-1:0]       clr_addr_r, clr_addr_nxt;

  logic [KEY_W-1:0]       in_key;
  logic [KEY_W-1:0]       probe_key;
  logic [PROD_W-1:0]      hash_prod;
  logic [IDX_W-1:0]       hash_slot;
  logic                   ent_valid;
  logic [KEY_W-1:0]       ent_key;
  logic [CODE_BITS-1:0]   ent_code;

  assign in_key    = {prefix_r, in_data_byte};
  assign probe_key = {prefix_r, byte_r};
  assign hash_prod = PROD_W'(in_key) * PROD_W'(LZWE_HASH_MULT);
  assign hash_slot = hash_prod[IDX_W-1:0];

  assign ent_valid = rd_data[ENT_W-1];
  assign ent_key   = rd_data[ENT_W-2 -: KEY_W];
  assign ent_code  = rd_data[CODE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      prefix_r      <= '0;
      have_prefix_r <= 1'b0;
      next_free_r   <= NF_W'(LZWE_FIRST_FREE);
      clr_addr_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      prefix_r      <= prefix_nxt;
      have_prefix_r <= have_prefix_nxt;
      next_free_r   <= next_free_nxt;
      clr_addr_r    <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    slot_r      <= slot_nxt;
    probe_cnt_r <= probe_cnt_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    prefix_nxt      = prefix_r;
    have_prefix_nxt = have_prefix_r;
    next_free_nxt   = next_free_r;
    byte_nxt        = byte_r;
    last_nxt        = last_r;
    slot_nxt        = slot_r;
    probe_cnt_nxt   = probe_cnt_r;
    clr_addr_nxt    = clr_addr_r;
    in_ready        = 1'b0;
    emit_valid      = 1'b0;
    emit_code       = prefix_r;
    emit_last       = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = hash_slot;
    wr_en           = 1'b0;
    wr_addr         = slot_r;
    wr_data         = {1'b1, probe_key, next_free_r[CODE_BITS-1:0]};

    case (state_r)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(HASH_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          byte_nxt = in_data_byte;
          last_nxt = in_end_of_input;
          if (!have_prefix_r) begin
            prefix_nxt      = CODE_BITS'(in_data_byte);
            have_prefix_nxt = 1'b1;
            state_nxt       = in_end_of_input ? ST_EMIT_PREFIX : ST_IDLE;
          end else begin
            rd_en         = 1'b1;
            slot_nxt      = hash_slot;
            probe_cnt_nxt = '0;
            state_nxt     = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        if (!ent_valid) begin
          // free slot: learn the string while codes remain
          if (!next_free_r[CODE_BITS]) begin
            wr_en         = 1'b1;
            next_free_nxt = next_free_r + 1'b1;
          end
          state_nxt = ST_EMIT_MISS;
        end else if (ent_key == probe_key) begin
          prefix_nxt = ent_code;
          state_nxt  = last_r ? ST_EMIT_PREFIX : ST_IDLE;
        end else if (probe_cnt_r == IDX_W'(HASH_ENTRIES - 1)) begin
          // every slot taken: emit without learning
          state_nxt = ST_EMIT_MISS;
        end else begin
          rd_en         = 1'b1;
          rd_addr       = slot_r + 1'b1;
          slot_nxt      = slot_r + 1'b1;
          probe_cnt_nxt = probe_cnt_r + 1'b1;
        end
      end

      ST_EMIT_MISS: begin
        emit_valid = 1'b1;
        if (emit_ready) begin
          prefix_nxt = CODE_BITS'(byte_r);
          state_nxt  = last_r ? ST_EMIT_PREFIX : ST_IDLE;
        end
      end

      ST_EMIT_PREFIX: begin
        emit_valid = 1'b1;
        if (emit_ready) begin
          state_nxt = ST_EMIT_TERM;
        end
      end

      ST_EMIT_TERM: begin
        emit_valid = 1'b1;
        emit_code  = CODE_BITS'(LZWE_TERM_CODE);
        emit_last  = 1'b1;
        if (emit_ready) begin
          state_nxt       = ST_CLEAR;
          clr_addr_nxt    = '0;
          prefix_nxt      = '0;
          have_prefix_nxt = 1'b0;
          next_free_nxt   = NF_W'(LZWE_FIRST_FREE);
        end
      end

      default: begin
        state_nxt    = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  a_code_space: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(1 << CODE_BITS))
    else $error("next free code ran past the code space");

  a_empty_dict: assert property (@(posedge clk) disable iff (!rst_n)
    !have_prefix_r |-> (next_free_r == NF_W'(LZWE_FIRST_FREE)))
    else $error("codes allocated with no prefix held");

  a_insert_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && wr_en) |-> !ent_valid)
    else $error("insert overwrote a live entry");

  a_term_then_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_valid && emit_ready && emit_last) |=> (state_r == ST_CLEAR && clr_addr_r == '0))
    else $error("terminator not followed by a table sweep");

endmodule

>>> hdl/lzw_encoder.sv
// ============================================================================
// lzw_encoder - LZW compressor with a hashed dictionary
// Byte stream in, dictionary codes out, with a zero terminator per stream.
// ============================================================================
// Feed one byte per word with end_of_input on the final byte of a stream; the
// block returns codes on the output channel, the terminator code 0 carrying
// last_result. Learned strings live in a single-port-read, single-port-write
// memory of HASH_ENTRIES slots (a power of two) holding {valid, prefix, byte,
// code}, probed linearly from a multiplicative hash. A byte that extends the
// prefix on its first probe is accepted, starting the registered memory read,
// then matched in the probe state; a byte that ends a match passes accept,
// probe with insert and emit; every collided slot adds another memory read.
// The final byte adds the prefix and terminator emits. After reset, and after
// each terminator is taken into the output register, the table is swept clear
// one slot a cycle, no byte being accepted meanwhile. Once all 2^CODE_BITS
// codes are given out, matching and emitting go on but no string is learned.
// The output register lets a finished code wait while the next byte is taken.
module lzw_encoder
  import lzwe_pkg::*;
#(
  parameter int CODE_BITS    = LZWE_CODE_BITS,
  parameter int HASH_ENTRIES = LZWE_HASH_ENTRIES,
  localparam int IDX_W       = $clog2(HASH_ENTRIES),
  localparam int ENT_W       = 1 + CODE_BITS + LZWE_BYTE_W + CODE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  lzwe_in_if.sink       in_ch,
  lzwe_out_if.source    out_ch
);

  // dictionary memory ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ENT_W-1:0] wr_data;

  // sequencer to output register
  logic                 emit_valid;
  logic                 emit_ready;
  logic [CODE_BITS-1:0] emit_code;
  logic                 emit_last;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] out_code_r;
  logic                 out_last_r;

  lzwe_ctrl #(
    .CODE_BITS    (CODE_BITS),
    .HASH_ENTRIES (HASH_ENTRIES)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data_byte    (in_ch.data_byte),
    .in_end_of_input (in_ch.end_of_input),
    .emit_valid      (emit_valid),
    .emit_ready      (emit_ready),
    .emit_code       (emit_code),
    .emit_last       (emit_last),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data)
  );

  lzwe_dict #(
    .CODE_BITS    (CODE_BITS),
    .HASH_ENTRIES (HASH_ENTRIES)
  ) u_dict (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // take a new code when the register is empty or its word leaves this cycle
  assign emit_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_valid && emit_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold payload until the word is taken
  always_ff @(posedge clk) begin
    if (emit_valid && emit_ready) begin
      out_code_r <= emit_code;
      out_last_r <= emit_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_code    = out_code_r;
  assign out_ch.last_result = out_last_r;

endmodule
